// ===== hdl/biprm_pkg.sv =====
// ----------------------------------------------------------------------------
// Register machine execution unit package
// Shared widths, types, opcode codes and decode helpers.
// ----------------------------------------------------------------------------
package biprm_pkg;

  localparam int unsigned RegCount = 6;
  localparam int unsigned RegIdxW  = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam int unsigned DataW    = 64;
  localparam int unsigned OperandW = 32;
  localparam int unsigned OutRegs  = 6;

  localparam int unsigned InFieldsW  = 4 + 2 * OperandW + 3;
  localparam int unsigned InTdataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = DataW + 2 + OutRegs * DataW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  localparam logic CfgIpRegister    = 1'b0;
  localparam logic CfgProgramLength = 1'b1;

  typedef logic [RegIdxW-1:0] reg_idx_t;
  typedef logic [DataW-1:0]   word_t;
  typedef word_t              reg_file_t [RegCount];

  typedef enum logic [3:0] {
    OpAddr = 4'd0,
    OpAddi = 4'd1,
    OpMulr = 4'd2,
    OpMuli = 4'd3,
    OpBanr = 4'd4,
    OpBani = 4'd5,
    OpBorr = 4'd6,
    OpBori = 4'd7,
    OpSetr = 4'd8,
    OpSeti = 4'd9,
    OpGtir = 4'd10,
    OpGtri = 4'd11,
    OpGtrr = 4'd12,
    OpEqir = 4'd13,
    OpEqri = 4'd14,
    OpEqrr = 4'd15
  } opcode_e;

  function automatic logic a_is_reg(opcode_e op);
    return !(op == OpSeti || op == OpGtir || op == OpEqir);
  endfunction

  function automatic logic b_is_reg(opcode_e op);
    return op == OpAddr || op == OpMulr || op == OpBanr || op == OpBorr ||
           op == OpGtir || op == OpGtrr || op == OpEqir || op == OpEqrr;
  endfunction

endpackage

// ===== hdl/bound_ip_register_machine_exec_unit.sv =====
// ----------------------------------------------------------------------------
// Bound instruction pointer register machine execution unit
// Executes one sixteen-opcode register machine instruction per input beat.
// ----------------------------------------------------------------------------
// Each input beat is latched in an input register and executed, once the output
// register is free or being taken, against the general registers and the stored
// instruction pointer; the result beat then sits in the output register until it
// is taken. The unit sustains one beat per cycle while the output side keeps
// taking beats, since the execute step reads and updates the register file
// combinationally, including the 64-bit wrapping multiply built from three
// 32-bit partial products. Configuration is to be written through the cfg port
// while the unit is idle; the unit leaves this to the user and always accepts it.
module bound_ip_register_machine_exec_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Fields from bit 0: opcode[3:0], operand_a[31:0], operand_b[31:0],
  // dest_index[2:0], zero padding.
  input  logic [biprm_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: next_ip[63:0], halted, fault, r0_value[63:0] through
  // r5_value[63:0], zero padding.
  output logic [biprm_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [15:0]                      cfg_data_i
);

  logic [biprm_pkg::InFieldsW-1:0]  in_data_q;
  logic                             in_valid_q;
  logic [biprm_pkg::OutTdataW-1:0]  out_data_q, out_data_d;
  logic                             out_valid_q;
  logic                             exec_fire;
  logic                             in_load;

  biprm_pkg::reg_file_t             regs_q, regs_d;
  biprm_pkg::word_t                 ip_q, ip_d;
  logic [2:0]                       cfg_ip_reg_q;
  logic [15:0]                      cfg_prog_len_q;

  biprm_pkg::opcode_e               op;
  logic [biprm_pkg::OperandW-1:0]   opnd_a, opnd_b;
  logic [2:0]                       dest;
  biprm_pkg::reg_idx_t              ip_idx, a_idx, b_idx, d_idx;
  biprm_pkg::reg_file_t             eff;
  biprm_pkg::word_t                 ra, rb, imm_a, imm_b, mul_y, res, bound_val;
  logic [63:0]                      prod_lo;
  logic [31:0]                      prod_x1, prod_x2;
  biprm_pkg::word_t                 prod;
  logic                             fault, ip_oor, halted;

  function automatic logic out_of_range(biprm_pkg::word_t p, logic [15:0] len);
    return p[63] || (p[63:16] != '0) || (p[15:0] >= len);
  endfunction

  assign exec_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign in_load       = !in_valid_q || exec_fire;
  assign s_axis_tready = in_load;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  assign op     = biprm_pkg::opcode_e'(in_data_q[3:0]);
  assign opnd_a = in_data_q[4 +: biprm_pkg::OperandW];
  assign opnd_b = in_data_q[4 + biprm_pkg::OperandW +: biprm_pkg::OperandW];
  assign dest   = in_data_q[4 + 2 * biprm_pkg::OperandW +: 3];

  assign ip_idx = biprm_pkg::reg_idx_t'(cfg_ip_reg_q);
  assign a_idx  = biprm_pkg::reg_idx_t'(opnd_a);
  assign b_idx  = biprm_pkg::reg_idx_t'(opnd_b);
  assign d_idx  = biprm_pkg::reg_idx_t'(dest);
  assign imm_a  = biprm_pkg::word_t'(opnd_a);
  assign imm_b  = biprm_pkg::word_t'(opnd_b);

  assign ip_oor = out_of_range(ip_q, cfg_prog_len_q);

  always_comb begin
    fault = 1'b0;
    if (ip_oor) begin
      fault = 1'b1;
    end else if (32'(cfg_ip_reg_q) >= 32'(biprm_pkg::RegCount) ||
                 32'(dest) >= 32'(biprm_pkg::RegCount)) begin
      fault = 1'b1;
    end else if (biprm_pkg::a_is_reg(op) && opnd_a >= 32'(biprm_pkg::RegCount)) begin
      fault = 1'b1;
    end else if (biprm_pkg::b_is_reg(op) && op != biprm_pkg::OpSetr &&
                 opnd_b >= 32'(biprm_pkg::RegCount)) begin
      fault = 1'b1;
    end
  end

  always_comb begin
    ra = '0;
    rb = '0;
    for (int i = 0; i < biprm_pkg::RegCount; i++) begin
      eff[i] = (ip_idx == biprm_pkg::reg_idx_t'(i)) ? ip_q : regs_q[i];
    end
    for (int i = 0; i < biprm_pkg::RegCount; i++) begin
      if (a_idx == biprm_pkg::reg_idx_t'(i)) begin
        ra = eff[i];
      end
      if (b_idx == biprm_pkg::reg_idx_t'(i)) begin
        rb = eff[i];
      end
    end
  end

  assign mul_y   = (op == biprm_pkg::OpMuli) ? imm_b : rb;
  assign prod_lo = ra[31:0] * mul_y[31:0];
  assign prod_x1 = ra[63:32] * mul_y[31:0];
  assign prod_x2 = ra[31:0] * mul_y[63:32];
  assign prod    = prod_lo + {prod_x1 + prod_x2, 32'b0};

  always_comb begin
    case (op)
      biprm_pkg::OpAddr: res = ra + rb;
      biprm_pkg::OpAddi: res = ra + imm_b;
      biprm_pkg::OpMulr: res = prod;
      biprm_pkg::OpMuli: res = prod;
      biprm_pkg::OpBanr: res = ra & rb;
      biprm_pkg::OpBani: res = ra & imm_b;
      biprm_pkg::OpBorr: res = ra | rb;
      biprm_pkg::OpBori: res = ra | imm_b;
      biprm_pkg::OpSetr: res = ra;
      biprm_pkg::OpSeti: res = imm_a;
      biprm_pkg::OpGtir: res = biprm_pkg::word_t'($signed(imm_a) > $signed(rb));
      biprm_pkg::OpGtri: res = biprm_pkg::word_t'($signed(ra) > $signed(imm_b));
      biprm_pkg::OpGtrr: res = biprm_pkg::word_t'($signed(ra) > $signed(rb));
      biprm_pkg::OpEqir: res = biprm_pkg::word_t'(imm_a == rb);
      biprm_pkg::OpEqri: res = biprm_pkg::word_t'(ra == imm_b);
      biprm_pkg::OpEqrr: res = biprm_pkg::word_t'(ra == rb);
      default:           res = '0;
    endcase
  end

  always_comb begin
    bound_val = (d_idx == ip_idx) ? res : ip_q;
    regs_d    = regs_q;
    ip_d      = ip_q;
    if (!fault) begin
      for (int i = 0; i < biprm_pkg::RegCount; i++) begin
        regs_d[i] = (d_idx == biprm_pkg::reg_idx_t'(i)) ? res : eff[i];
      end
      ip_d = bound_val + 64'd1;
    end
    halted = out_of_range(ip_d, cfg_prog_len_q);
  end

  always_comb begin
    out_data_d = '0;
    out_data_d[63:0] = ip_d;
    out_data_d[64]   = halted;
    out_data_d[65]   = fault;
    for (int i = 0; i < biprm_pkg::OutRegs; i++) begin
      if (i < biprm_pkg::RegCount) begin
        out_data_d[66 + i * biprm_pkg::DataW +: biprm_pkg::DataW] = regs_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      ip_q           <= '0;
      cfg_ip_reg_q   <= '0;
      cfg_prog_len_q <= '0;
      for (int i = 0; i < biprm_pkg::RegCount; i++) begin
        regs_q[i] <= (i == 0) ? 64'd1 : 64'd0;
      end
    end else begin
      if (in_load) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
        regs_q      <= regs_d;
        ip_q        <= ip_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          biprm_pkg::CfgIpRegister:    cfg_ip_reg_q   <= cfg_data_i[2:0];
          biprm_pkg::CfgProgramLength: cfg_prog_len_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[biprm_pkg::InFieldsW-1:0];
    end
    if (exec_fire) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Register machine execution unit testbench
// Streams instruction beats into the unit and checks every result beat against
// a cycle-free model of the six-register machine and its bound pointer. A short
// directed program covers every opcode, wrap-around and the fault cases. It is
// followed by random phases, each with its own bound register and program
// length, in which, unless the phase allows halting, the generator steers jumps
// so that the pointer stays in range. Both stream sides idle at random, and the
// run ends by driving the pointer negative.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WatchdogLimit = 2000;

  typedef struct packed {
    logic [2:0]           dest;
    logic [31:0]          b;
    logic [31:0]          a;
    biprm_pkg::opcode_e   op;
  } instr_t;

  typedef struct packed {
    logic [biprm_pkg::OutRegs-1:0][63:0] gpr;
    logic                                fault;
    logic                                halted;
    logic [63:0]                         next_ip;
  } retire_t;

  typedef struct packed {
    logic [biprm_pkg::RegCount-1:0][63:0] gpr;
    logic [63:0]                          ip;
  } machine_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic [biprm_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [biprm_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic                            cfg_index_i = 1'b0;
  logic [15:0]                     cfg_data_i = '0;

  bound_ip_register_machine_exec_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  instr_t      instr_q[$];
  retire_t     retire_q[$];
  machine_t    arch;
  logic [2:0]  cfg_ip_sel;
  logic [15:0] cfg_len;
  bit          in_burst;
  bit          out_burst;
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned gap_now;
  int unsigned stall_now;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  retire_t     got;
  retire_t     want;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic uses_a_reg(biprm_pkg::opcode_e op);
    return !(op == biprm_pkg::OpSeti || op == biprm_pkg::OpGtir || op == biprm_pkg::OpEqir);
  endfunction

  function automatic logic uses_b_reg(biprm_pkg::opcode_e op);
    return op == biprm_pkg::OpAddr || op == biprm_pkg::OpMulr ||
           op == biprm_pkg::OpBanr || op == biprm_pkg::OpBorr ||
           op == biprm_pkg::OpGtir || op == biprm_pkg::OpGtrr ||
           op == biprm_pkg::OpEqir || op == biprm_pkg::OpEqrr;
  endfunction

  function automatic logic ptr_out(logic [63:0] p);
    return p[63] || p >= {48'd0, cfg_len};
  endfunction

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic retire_t execute_instr(instr_t it, inout machine_t m);
    retire_t     r;
    logic        a_reg;
    logic        b_reg;
    logic        bad;
    logic [63:0] ra;
    logic [63:0] rb;
    logic [63:0] ia;
    logic [63:0] ib;
    logic [63:0] res;
    a_reg = uses_a_reg(it.op);
    b_reg = uses_b_reg(it.op);
    ia = {32'd0, it.a};
    ib = {32'd0, it.b};
    bad = ptr_out(m.ip) || cfg_ip_sel >= biprm_pkg::RegCount ||
          it.dest >= biprm_pkg::RegCount ||
          (a_reg && it.a >= biprm_pkg::RegCount) || (b_reg && it.b >= biprm_pkg::RegCount);
    if (!bad) begin
      m.gpr[cfg_ip_sel] = m.ip;
      ra = a_reg ? m.gpr[it.a[2:0]] : 64'd0;
      rb = b_reg ? m.gpr[it.b[2:0]] : 64'd0;
      case (it.op)
        biprm_pkg::OpAddr: res = ra + rb;
        biprm_pkg::OpAddi: res = ra + ib;
        biprm_pkg::OpMulr: res = ra * rb;
        biprm_pkg::OpMuli: res = ra * ib;
        biprm_pkg::OpBanr: res = ra & rb;
        biprm_pkg::OpBani: res = ra & ib;
        biprm_pkg::OpBorr: res = ra | rb;
        biprm_pkg::OpBori: res = ra | ib;
        biprm_pkg::OpSetr: res = ra;
        biprm_pkg::OpSeti: res = ia;
        biprm_pkg::OpGtir: res = {63'd0, $signed(ia) > $signed(rb)};
        biprm_pkg::OpGtri: res = {63'd0, $signed(ra) > $signed(ib)};
        biprm_pkg::OpGtrr: res = {63'd0, $signed(ra) > $signed(rb)};
        biprm_pkg::OpEqir: res = {63'd0, ia == rb};
        biprm_pkg::OpEqri: res = {63'd0, ra == ib};
        default: res = {63'd0, ra == rb};
      endcase
      m.gpr[it.dest] = res;
      m.ip = m.gpr[cfg_ip_sel] + 64'd1;
    end
    r.next_ip = m.ip;
    r.halted = ptr_out(m.ip);
    r.fault = bad;
    r.gpr = '0;
    for (int i = 0; i < biprm_pkg::RegCount; i++) r.gpr[i] = m.gpr[i];
    return r;
  endfunction

  function automatic void issue(instr_t it);
    retire_q.insert(retire_q.size(), execute_instr(it, arch));
    instr_q.insert(instr_q.size(), it);
  endfunction

  function automatic instr_t mk(biprm_pkg::opcode_e op, logic [31:0] a, logic [31:0] b,
                                logic [2:0] d);
    instr_t it;
    it.op = op;
    it.a = a;
    it.b = b;
    it.dest = d;
    return it;
  endfunction

  function automatic logic [31:0] pick_operand(logic as_reg);
    if (as_reg) return $urandom_range(0, biprm_pkg::RegCount - 1);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16);
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t     it;
    logic [3:0] opv;
    opv = 4'($urandom_range(0, 15));
    it.op = biprm_pkg::opcode_e'(opv);
    it.a = pick_operand(uses_a_reg(it.op));
    it.b = pick_operand(uses_b_reg(it.op));
    it.dest = 3'($urandom_range(0, biprm_pkg::RegCount - 1));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: it.dest = 3'($urandom_range(biprm_pkg::RegCount, 7));
        1: it.a = $urandom_range(0, 1) ? $urandom_range(biprm_pkg::RegCount, 7) : $urandom;
        default: it.b = $urandom_range(0, 1) ? $urandom_range(biprm_pkg::RegCount, 7)
                                             : $urandom;
      endcase
    end
    return it;
  endfunction

  task automatic cfg_write(logic index, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [2:0] ip_sel, logic [15:0] len);
    logic [12:0] upper;
    upper = $urandom_range(0, 1) ? 13'($urandom) : 13'd0;
    cfg_write(biprm_pkg::CfgIpRegister, {upper, ip_sel});
    cfg_write(biprm_pkg::CfgProgramLength, len);
    cfg_ip_sel = ip_sel;
    cfg_len = len;
  endtask

  task automatic drain();
    while (instr_q.size() != 0 || retire_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random instructions that move the pointer out of bounds (in halting phases,
  // only to 65535 or more) become a jump into the program, or a refused beat.
  task automatic run_phase(logic [2:0] ip_sel, logic [15:0] len, int count, bit allow_halt);
    machine_t trial;
    instr_t   it;
    retire_t  r;
    drain();
    if (!allow_halt) begin
      if (arch.ip >= {48'd0, len}) len = arch.ip[15:0] + 16'd1;
      if (len < 16'd2) len = 16'd2;
    end
    set_config(ip_sel, len);
    @(negedge clk_i);
    in_burst = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      it = random_instr();
      trial = arch;
      r = execute_instr(it, trial);
      if (r.halted && !r.fault && (!allow_halt || r.next_ip >= 64'd65535)) begin
        if (cfg_len >= 16'd2) begin
          it = mk(biprm_pkg::OpSeti, $urandom_range(0, cfg_len - 2), $urandom, cfg_ip_sel);
        end else begin
          it.dest = 3'd7;
        end
      end
      issue(it);
    end
    if (cfg_ip_sel < biprm_pkg::RegCount) begin
      issue(mk(biprm_pkg::OpSeti, 32'd0, $urandom, cfg_ip_sel));
    end
  endtask

  initial begin
    arch.gpr = '0;
    arch.gpr[0] = 64'd1;
    arch.ip = 64'd0;
    cfg_ip_sel = 3'd0;
    cfg_len = 16'd0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    issue(mk(biprm_pkg::OpSeti, 32'd3, 32'd0, 3'd1));

    drain();
    set_config(3'd2, 16'd64);
    @(negedge clk_i);
    issue(mk(biprm_pkg::OpSeti, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd1));
    issue(mk(biprm_pkg::OpAddi, 32'd1, 32'd2, 3'd3));
    issue(mk(biprm_pkg::OpMulr, 32'd1, 32'd3, 3'd4));
    issue(mk(biprm_pkg::OpMuli, 32'd4, 32'h8000_0000, 3'd5));
    issue(mk(biprm_pkg::OpBanr, 32'd4, 32'd5, 3'd0));
    issue(mk(biprm_pkg::OpBani, 32'd4, 32'hFFFF_FFFF, 3'd0));
    issue(mk(biprm_pkg::OpBorr, 32'd1, 32'd5, 3'd5));
    issue(mk(biprm_pkg::OpBori, 32'd0, 32'h1234_5678, 3'd0));
    issue(mk(biprm_pkg::OpSetr, 32'd4, 32'hFFFF_FFFF, 3'd1));
    issue(mk(biprm_pkg::OpGtir, 32'hFFFF_FFFF, 32'd4, 3'd0));
    issue(mk(biprm_pkg::OpGtri, 32'd4, 32'd0, 3'd0));
    issue(mk(biprm_pkg::OpGtrr, 32'd3, 32'd4, 3'd0));
    issue(mk(biprm_pkg::OpEqir, 32'hFFFF_FFFF, 32'd2, 3'd0));
    issue(mk(biprm_pkg::OpEqri, 32'd0, 32'd0, 3'd0));
    issue(mk(biprm_pkg::OpEqrr, 32'd4, 32'd1, 3'd0));
    issue(mk(biprm_pkg::OpAddr, 32'd4, 32'd4, 3'd3));
    // Loading all ones into the bound register wraps the pointer to zero.
    issue(mk(biprm_pkg::OpSetr, 32'd4, 32'd0, 3'd2));
    issue(mk(biprm_pkg::OpAddr, 32'd6, 32'd0, 3'd0));
    issue(mk(biprm_pkg::OpMulr, 32'd0, 32'hFFFF_FFFF, 3'd0));
    issue(mk(biprm_pkg::OpAddi, 32'd0, 32'd1, 3'd6));
    issue(mk(biprm_pkg::OpSeti, 32'd5, 32'd7, 3'd7));
    issue(mk(biprm_pkg::OpAddi, 32'd2, 32'd10, 3'd2));
    issue(mk(biprm_pkg::OpEqrr, 32'd2, 32'd2, 3'd4));

    run_phase(3'd0, 16'hFFFF, 200, 1'b0);
    run_phase(3'd5, 16'd2, 150, 1'b0);
    run_phase(3'd7, 16'd100, 20, 1'b0);
    run_phase(3'd6, 16'd100, 20, 1'b0);
    run_phase(3'd3, 16'd1, 20, 1'b1);
    run_phase(3'd1, 16'd0, 20, 1'b1);
    repeat (11) begin
      run_phase(3'($urandom_range(0, biprm_pkg::RegCount - 1)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(2, 65535))
                                            : 16'($urandom_range(2, 64)),
                130, $urandom_range(0, 3) == 0);
    end

    // Two times all ones in the bound register drives the pointer negative.
    drain();
    set_config(3'd0, 16'hFFFF);
    @(negedge clk_i);
    issue(mk(biprm_pkg::OpSeti, 32'hFFFF_FFFF, 32'd0, 3'd1));
    issue(mk(biprm_pkg::OpAddi, 32'd1, 32'd2, 3'd2));
    issue(mk(biprm_pkg::OpMulr, 32'd1, 32'd2, 3'd3));
    issue(mk(biprm_pkg::OpAddr, 32'd3, 32'd3, 3'd4));
    issue(mk(biprm_pkg::OpSetr, 32'd4, 32'd0, 3'd0));
    issue(mk(biprm_pkg::OpAddi, 32'd1, 32'd1, 3'd1));

    drain();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && retire_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      in_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      gap_now = in_gap;
      if (s_axis_tvalid) begin
        void'(instr_q.pop_front());
        gap_now = draw_gap(in_burst);
      end
      if (gap_now == 0 && instr_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= biprm_pkg::InTdataW'(instr_q[0]);
      end else begin
        s_axis_tvalid <= 1'b0;
        if (gap_now != 0) gap_now = gap_now - 1;
      end
      in_gap <= gap_now;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_gap <= 0;
      mismatch_count = 0;
    end else begin
      stall_now = out_gap;
      if (m_axis_tvalid && m_axis_tready) begin
        got = retire_t'(m_axis_tdata[biprm_pkg::OutFieldsW-1:0]);
        if (retire_q.size() == 0) begin
          $error("result beat with no instruction outstanding");
          mismatch_count++;
        end else begin
          want = retire_q.pop_front();
          if (got.next_ip !== want.next_ip) begin
            $error("next_ip: expected %h, got %h", want.next_ip, got.next_ip);
            mismatch_count++;
          end
          if (got.halted !== want.halted) begin
            $error("halted: expected %b, got %b", want.halted, got.halted);
            mismatch_count++;
          end
          if (got.fault !== want.fault) begin
            $error("fault: expected %b, got %b", want.fault, got.fault);
            mismatch_count++;
          end
          for (int i = 0; i < biprm_pkg::OutRegs; i++) begin
            if (got.gpr[i] !== want.gpr[i]) begin
              $error("r%0d_value: expected %h, got %h", i, want.gpr[i], got.gpr[i]);
              mismatch_count++;
            end
          end
        end
        stall_now = draw_gap(out_burst);
      end
      if (stall_now == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_now = stall_now - 1;
      end
      out_gap <= stall_now;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
hdl/biprm_pkg.sv
hdl/bound_ip_register_machine_exec_unit.sv
tb/sv/testbench.sv
